FILE: rtl/core/rlbd_pkg.sv
// Shared types and constants for the run-length bitmap decoder.
`timescale 1ns / 1ps

package rlbd_pkg;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_SPECIAL_MARKER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPECIAL_RUN    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TOTAL_PIXELS   = 2'd2;

  // Register reset values
  localparam logic [7:0]  SPECIAL_MARKER_RESET = 8'hff;
  localparam logic [15:0] SPECIAL_RUN_RESET    = 16'd16384;
  localparam logic [23:0] TOTAL_PIXELS_RESET   = 24'd4915200;

  // Decoded run lengths (special, extended, combined) all fit in 16 bits
  localparam int LEN_W = 16;
  localparam int HOLD_BIT = 7;     // length byte flag: hold as extended run
  localparam int HOLD_SHIFT = 7;   // extended run unit is 128 pixels

  // One decoded run waiting to be emitted
  typedef struct packed {
    logic             valid;
    logic [7:0]       color;
    logic [LEN_W-1:0] len;
  } run_op_t;

  // Which pending run the emitter takes this cycle
  typedef enum logic [2:0] {
    SEL_NONE,
    SEL_FIRST,
    SEL_SECOND,
    SEL_FILL,
    SEL_PAD
  } run_sel_t;

endpackage

FILE: rtl/core/run_length_bitmap_decoder.sv
// Run-length bitmap decoder: (color, length byte) pairs in, clipped pixel runs out.
`timescale 1ns / 1ps
// Path: a pair's runs pass through the pending-run register, then the output register.
// Throughput: with out_stall low, one pair per cycle when a pair yields at most one
//   run; a pair yielding n runs (n <= 3) holds the pending-run register until all are
//   sent, since the emitter clips and sends one run per cycle against the remaining frame room.
// Pairs that yield no run (held extended length, full frame) do not stall the input.
// Reset (rst, synchronous): registers go to their reset values, no held pair, frame empty.

module run_length_bitmap_decoder #(
  parameter int MAX_PIXELS_LOG2 = 23
) (
  input  logic                                clk,
  input  logic                                rst,
  // configuration write port
  input  logic                                cfg_write,
  input  logic [rlbd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [MAX_PIXELS_LOG2-1:0]          cfg_data,
  // compressed pair input
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [7:0]                          pair_color,
  input  logic [7:0]                          pair_len,
  input  logic                                last_pair,
  // run output
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [7:0]                          run_color,
  output logic [MAX_PIXELS_LOG2-1:0]          run_pixels,
  output logic                                is_padding,
  output logic                                last_run
);
  import rlbd_pkg::*;

  localparam int PIX_W = MAX_PIXELS_LOG2;
  localparam logic [PIX_W-1:0] TOTAL_RST = PIX_W'(TOTAL_PIXELS_RESET);

  // Configuration registers
  logic [7:0]       special_marker;
  logic [15:0]      special_run;
  logic [PIX_W-1:0] total_pixels;

  // Held extended-length pair
  logic             held_valid;
  logic [7:0]       held_color;
  logic [6:0]       held_length_low;

  // Frame progress; room mirrors max(total_pixels - pixels_done, 0)
  logic [PIX_W-1:0] pixels_done;
  logic [PIX_W-1:0] room;

  // Pending runs of the current word
  run_op_t          op_a;        // combined or flushed held run
  run_op_t          op_b;        // marker or short run
  logic             fill_valid;  // held color fills the rest of the frame
  logic [7:0]       fill_color;
  logic             pad_valid;   // padding closes the frame
  logic             frame_end;

  // Emitter
  logic             busy;
  logic             room_nz;
  run_sel_t         sel;
  logic [PIX_W-1:0] sel_len;
  logic [7:0]       sel_color;
  logic             sel_pad;
  logic             has_run;
  logic             out_free;
  logic             fire;
  logic             advance;
  logic             clip_full;
  logic [PIX_W-1:0] run_len;
  logic             a_keep, b_keep, fill_keep, pad_keep;
  logic             list_done;
  logic             accept;
  logic             gate;

  // Decode
  logic             dec_comb, dec_flush, dec_mark, dec_hold, dec_norm;
  logic [LEN_W-1:0] held_run;
  logic [LEN_W-1:0] short_run;
  run_op_t          dec_a;
  run_op_t          dec_b;
  logic             hv_after;
  logic [7:0]       hc_after;
  logic [6:0]       hl_after;
  logic [PIX_W-1:0] cfg_room;

  assign busy    = op_a.valid | op_b.valid | fill_valid | pad_valid;
  assign room_nz = (room != '0);

  // Pick the next run that can produce pixels; a zero special length is skipped
  always_comb begin
    if (op_a.valid) begin
      sel = SEL_FIRST;
    end else if (op_b.valid && (op_b.len != '0)) begin
      sel = SEL_SECOND;
    end else if (fill_valid) begin
      sel = SEL_FILL;
    end else if (pad_valid) begin
      sel = SEL_PAD;
    end else begin
      sel = SEL_NONE;
    end
  end

  always_comb begin
    unique case (sel)
      SEL_FIRST: begin
        sel_len   = PIX_W'(op_a.len);
        sel_color = op_a.color;
        sel_pad   = 1'b0;
      end
      SEL_SECOND: begin
        sel_len   = PIX_W'(op_b.len);
        sel_color = op_b.color;
        sel_pad   = 1'b0;
      end
      SEL_FILL: begin
        sel_len   = room;
        sel_color = fill_color;
        sel_pad   = 1'b0;
      end
      SEL_PAD: begin
        sel_len   = room;
        sel_color = 8'd0;
        sel_pad   = 1'b1;
      end
      default: begin
        sel_len   = '0;
        sel_color = 8'd0;
        sel_pad   = 1'b0;
      end
    endcase
  end

  assign has_run   = room_nz && (sel != SEL_NONE);
  assign out_free  = !out_valid || !out_stall;
  assign fire      = has_run && out_free;
  assign advance   = busy && (!has_run || out_free);
  // a run that reaches the frame end leaves nothing for the runs after it
  assign clip_full = (sel_len >= room);
  assign run_len   = clip_full ? room : sel_len;

  always_comb begin
    a_keep    = op_a.valid;
    b_keep    = op_b.valid;
    fill_keep = fill_valid;
    pad_keep  = pad_valid;
    if (advance) begin
      if (!has_run || clip_full) begin
        a_keep    = 1'b0;
        b_keep    = 1'b0;
        fill_keep = 1'b0;
        pad_keep  = 1'b0;
      end else begin
        case (sel)
          SEL_FIRST:  a_keep    = 1'b0;
          SEL_SECOND: b_keep    = 1'b0;
          SEL_FILL:   fill_keep = 1'b0;
          SEL_PAD:    pad_keep  = 1'b0;
          default:    a_keep    = op_a.valid;
        endcase
      end
    end
  end

  assign list_done = advance && !(a_keep | b_keep | fill_keep | pad_keep);
  assign in_stall  = busy && !list_done;
  assign accept    = in_valid && !in_stall;

  // Whether frame room is left for the new word, after this cycle's run or frame clear
  always_comb begin
    if (list_done && frame_end) begin
      gate = (total_pixels != '0);
    end else if (fire) begin
      gate = !clip_full;
    end else begin
      gate = room_nz;
    end
  end

  // Pair decode
  assign held_run  = (LEN_W'(held_length_low) + LEN_W'(1)) << HOLD_SHIFT;
  assign short_run = LEN_W'(pair_len) + LEN_W'(1);

  always_comb begin
    dec_comb  = gate && held_valid && (pair_color == held_color);
    dec_flush = gate && held_valid && !dec_comb;
    dec_mark  = gate && !dec_comb && (pair_len == special_marker);
    dec_hold  = gate && !dec_comb && !dec_mark && pair_len[HOLD_BIT];
    dec_norm  = gate && !dec_comb && !dec_mark && !pair_len[HOLD_BIT];

    dec_a.valid = dec_comb | dec_flush;
    dec_a.color = dec_comb ? pair_color : held_color;
    dec_a.len   = dec_comb ? (held_run + short_run) : held_run;

    dec_b.valid = dec_mark | dec_norm;
    dec_b.color = pair_color;
    dec_b.len   = dec_mark ? special_run : short_run;

    hv_after = dec_hold | (held_valid && !gate);
    hc_after = dec_hold ? pair_color : held_color;
    hl_after = dec_hold ? pair_len[HOLD_BIT-1:0] : held_length_low;
  end

  assign cfg_room = (cfg_data > pixels_done) ? (cfg_data - pixels_done) : '0;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      special_marker <= SPECIAL_MARKER_RESET;
      special_run    <= SPECIAL_RUN_RESET;
      total_pixels   <= TOTAL_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_SPECIAL_MARKER: special_marker <= cfg_data[7:0];
        REG_SPECIAL_RUN:    special_run    <= cfg_data[15:0];
        REG_TOTAL_PIXELS:   total_pixels   <= cfg_data;
        default:            special_marker <= special_marker;
      endcase
    end
  end

  // Frame progress
  always_ff @(posedge clk) begin
    if (rst) begin
      pixels_done <= '0;
      room        <= TOTAL_RST;
    end else if (cfg_write && (cfg_index == REG_TOTAL_PIXELS)) begin
      room <= cfg_room;
    end else if (list_done && frame_end) begin
      pixels_done <= '0;
      room        <= total_pixels;
    end else if (fire) begin
      pixels_done <= pixels_done + run_len;
      room        <= clip_full ? '0 : (room - sel_len);
    end
  end

  // Held pair; cleared at frame end
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid      <= 1'b0;
      held_color      <= 8'd0;
      held_length_low <= 7'd0;
    end else if (accept) begin
      held_valid      <= hv_after && !last_pair;
      held_color      <= last_pair ? 8'd0 : hc_after;
      held_length_low <= last_pair ? 7'd0 : hl_after;
    end
  end

  // Pending-run register
  always_ff @(posedge clk) begin
    if (rst) begin
      op_a.valid <= 1'b0;
      op_b.valid <= 1'b0;
      fill_valid <= 1'b0;
      pad_valid  <= 1'b0;
      frame_end  <= 1'b0;
    end else if (accept) begin
      op_a       <= dec_a;
      op_b       <= dec_b;
      fill_valid <= last_pair && hv_after;
      fill_color <= hc_after;
      pad_valid  <= last_pair;
      frame_end  <= last_pair;
    end else begin
      op_a.valid <= a_keep;
      op_b.valid <= b_keep;
      fill_valid <= fill_keep;
      pad_valid  <= pad_keep;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= fire;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      run_color  <= sel_color;
      run_pixels <= run_len;
      is_padding <= sel_pad;
      last_run   <= frame_end && clip_full;
    end
  end

endmodule

FILE: rtl/core/rlbd_checker.sv
// Port-level assertions for the run-length bitmap decoder, with its bind.
`timescale 1ns / 1ps

module rlbd_checker #(
  parameter int PIX_W = 23
) (
  input logic             clk,
  input logic             rst,
  input logic             out_valid,
  input logic             out_stall,
  input logic [7:0]       run_color,
  input logic [PIX_W-1:0] run_pixels,
  input logic             is_padding,
  input logic             last_run
);

  // stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(run_pixels) && $stable(run_color)
      && $stable(is_padding) && $stable(last_run))
    else $error("stalled run changed");

  a_no_empty_run: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> run_pixels != '0)
    else $error("run of zero pixels");

  a_pad_color: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_padding |-> run_color == 8'd0)
    else $error("padding run with nonzero color");

  a_pad_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_padding |-> last_run)
    else $error("padding run not marked last");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind run_length_bitmap_decoder rlbd_checker #(.PIX_W(MAX_PIXELS_LOG2)) u_rlbd_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .run_color  (run_color),
  .run_pixels (run_pixels),
  .is_padding (is_padding),
  .last_run   (last_run)
);
